/* src/nearest_key_table_lookup_assert.svh */
// ---------------------------------------------------------------------------
// Nearest-key table lookup: assertion macros
// Shorthand for concurrent checks clocked on clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef NEAREST_KEY_TABLE_LOOKUP_ASSERT_SVH
`define NEAREST_KEY_TABLE_LOOKUP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define NKTL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define NKTL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/nktl_pkg.sv */
// ---------------------------------------------------------------------------
// nktl_pkg
// Shared types and constants of the nearest-key table lookup.
// ---------------------------------------------------------------------------
package nktl_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 31;
	localparam int VAL_W       = 64;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_BELOW = 3'd1,
		ST_ABOVE = 3'd2,
		ST_EMPTY = 3'd3,
		ST_FULL  = 3'd4
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_SCAN
	} fsm_t;

	typedef struct packed {
		action_t            action;
		logic [KEY_W-1:0]   key;
		logic signed [VAL_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		status_t            status;
		logic signed [VAL_W-1:0] result_value;
	} out_word_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
	} mem_word_t;

	typedef struct packed {
		logic               re;
		logic [ADDR_W-1:0]  raddr;
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		mem_word_t          wdata;
	} mem_req_t;

endpackage

/* src/nktl_mem.sv */
// ---------------------------------------------------------------------------
// nktl_mem
// Key/value store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module nktl_mem (
	input  logic                 clk,
	input  nktl_pkg::mem_req_t   req,
	output nktl_pkg::mem_word_t  rdata
);
	import nktl_pkg::*;

	mem_word_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

/* src/nktl_seq.sv */
// ---------------------------------------------------------------------------
// nktl_seq
// Scan sequencer: sweeps the stored entries, tracks the match and the
// nearest keys on either side, then issues the result (an insert writes back first).
// ---------------------------------------------------------------------------
module nktl_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  nktl_pkg::in_word_t   item,
	output logic                 busy,
	output logic                 done,
	output nktl_pkg::out_word_t  result,
	output nktl_pkg::mem_req_t   mem_req,
	input  nktl_pkg::mem_word_t  mem_rdata
);
	import nktl_pkg::*;

	fsm_t              state_q, state_d;
	in_word_t          item_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              rvalid_s1;
	logic [ADDR_W-1:0] ridx_s1;
	logic              have_lo_q, have_hi_q, match_q;
	logic [ADDR_W-1:0] match_idx_q;
	logic [KEY_W-1:0]  lo_key_q, hi_key_q;
	logic [VAL_W-1:0]  lo_val_q, hi_val_q;
	logic              done_q;
	out_word_t         result_q;

	logic              accept, fin, full;
	logic              k_le, lo_upd, hi_upd;
	logic [KEY_W-1:0]  d_lo, d_hi;
	out_word_t         fin_res;

	assign busy   = (state_q != FSM_IDLE);
	assign done   = done_q;
	assign result = result_q;
	assign full   = (cnt_q == CNT_W'(TABLE_DEPTH));

	// fold of one returned entry
	assign k_le   = (mem_rdata.key <= item_q.key);
	assign lo_upd = k_le && (!have_lo_q || (mem_rdata.key > lo_key_q));
	assign hi_upd = !k_le && (!have_hi_q || (mem_rdata.key < hi_key_q));

	assign d_lo = item_q.key - lo_key_q;
	assign d_hi = hi_key_q - item_q.key;

	always_comb begin
		fin_res = '{status: ST_OK, result_value: '0};
		if (item_q.action == ACT_INSERT) begin
			if (!match_q && full) begin
				fin_res.status = ST_FULL;
			end
		end else if (cnt_q == '0) begin
			fin_res.status = ST_EMPTY;
		end else if (!have_hi_q) begin
			if (have_lo_q && (lo_key_q == item_q.key)) begin
				fin_res.result_value = lo_val_q;
			end else begin
				fin_res.status = ST_ABOVE;
			end
		end else if (!have_lo_q) begin
			fin_res.status = ST_BELOW;
		end else begin
			fin_res.result_value = (d_lo < d_hi) ? lo_val_q : hi_val_q;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_req = '0;
		accept  = 1'b0;
		fin     = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				if (start) begin
					accept = 1'b1;
					if (item.action inside {ACT_INSERT, ACT_QUERY}) begin
						state_d = FSM_SCAN;
					end
				end
			end
			FSM_SCAN: begin
				if (rd_cnt_q < cnt_q) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = rd_cnt_q[ADDR_W-1:0];
				end else if (!rvalid_s1) begin
					fin     = 1'b1;
					state_d = FSM_IDLE;
					if ((item_q.action == ACT_INSERT) && (match_q || !full)) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = match_q ? match_idx_q : cnt_q[ADDR_W-1:0];
						mem_req.wdata = '{key: item_q.key, value: item_q.value};
					end
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_cnt_q  <= '0;
			rvalid_s1 <= 1'b0;
			have_lo_q <= 1'b0;
			have_hi_q <= 1'b0;
			match_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= fin || (accept && !(item.action inside {ACT_INSERT, ACT_QUERY}));
			rvalid_s1 <= mem_req.re;
			if (mem_req.re) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			if (rvalid_s1) begin
				if (lo_upd) have_lo_q <= 1'b1;
				if (hi_upd) have_hi_q <= 1'b1;
				if (mem_rdata.key == item_q.key) match_q <= 1'b1;
			end
			if (accept) begin
				rd_cnt_q  <= '0;
				have_lo_q <= 1'b0;
				have_hi_q <= 1'b0;
				match_q   <= 1'b0;
				if (item.action == ACT_CLEAR) begin
					cnt_q <= '0;
				end
			end
			if (fin) begin
				if (mem_req.we && !match_q) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= item;
			result_q <= '{status: ST_OK, result_value: '0};
		end
		if (mem_req.re) begin
			ridx_s1 <= mem_req.raddr;
		end
		if (rvalid_s1) begin
			if (lo_upd) begin
				lo_key_q <= mem_rdata.key;
				lo_val_q <= mem_rdata.value;
			end
			if (hi_upd) begin
				hi_key_q <= mem_rdata.key;
				hi_val_q <= mem_rdata.value;
			end
			if (mem_rdata.key == item_q.key) begin
				match_idx_q <= ridx_s1;
			end
		end
		if (fin) begin
			result_q <= fin_res;
		end
	end

endmodule

/* src/nearest_key_table_lookup.sv */
// ---------------------------------------------------------------------------
// nearest_key_table_lookup
// Key/value table with insert, nearest-key query and clear words.
// ---------------------------------------------------------------------------
// Insert and query: a sweep of the N stored entries, one memory read a cycle;
//   once the last read data is folded in, done rises, registered from the
//   finishing step, which on an empty table follows acceptance directly.
// Clear and the unused action: done rises the cycle after acceptance.
// A new word may be accepted in the cycle that done is high.
// Reset empties the table; entry contents are left as they are.
module nearest_key_table_lookup (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  nktl_pkg::in_word_t   item,
	output logic                 done,
	output nktl_pkg::out_word_t  result
);
	import nktl_pkg::*;

	mem_req_t  mem_req;
	mem_word_t mem_rdata;

	nktl_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	nktl_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

`include "nearest_key_table_lookup_assert.svh"

	`NKTL_ASSERT_NOW(a_write_busy, mem_req.we, busy, "store written while idle")
	`NKTL_ASSERT_NOW(a_rw_excl, mem_req.re, !mem_req.we, "read and write in one cycle")
	`NKTL_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
	`NKTL_ASSERT_NEXT(a_fin_done, busy && mem_req.we, done, "write-back without result")

endmodule
